### design/combined_mrg_order3_rng_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the order-3 combined MRG block
// Concurrent checks that vanish from synthesis builds
// ----------------------------------------------------------------------------
`ifndef COMBINED_MRG_ORDER3_RNG_TOP_DEFINES_SVH
`define COMBINED_MRG_ORDER3_RNG_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define MRG3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define MRG3_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MRG3_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define MRG3_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/mrg3_pkg.sv
// ----------------------------------------------------------------------------
// mrg3_pkg
// Constants, control types and sequencer states for the combined MRG block
// ----------------------------------------------------------------------------
`default_nettype none

package mrg3_pkg;

  localparam int LAG_W  = 32;
  localparam int COEF_W = 22;
  localparam int ACC_W  = COEF_W + LAG_W;
  localparam int IDX_W  = 3;

  localparam logic [LAG_W-1:0] MOD_ONE  = 32'd4294967087;
  localparam logic [LAG_W-1:0] MOD_TWO  = 32'd4294944443;
  // 2^32 mod m for each component
  localparam logic [LAG_W-1:0] FOLD_ONE = 32'd209;
  localparam logic [LAG_W-1:0] FOLD_TWO = 32'd22853;

  localparam logic [COEF_W-1:0] MUL_ONE_A = 22'd1403580;
  localparam logic [COEF_W-1:0] MUL_ONE_B = 22'd810728;
  localparam logic [COEF_W-1:0] MUL_TWO_A = 22'd527612;
  localparam logic [COEF_W-1:0] MUL_TWO_B = 22'd1370589;

  localparam logic [LAG_W-1:0] SEED_FIRST_OLDEST_RST  = 32'd231458761;
  localparam logic [LAG_W-1:0] SEED_FIRST_MIDDLE_RST  = 32'd34125679;
  localparam logic [LAG_W-1:0] SEED_FIRST_NEWEST_RST  = 32'd45678213;
  localparam logic [LAG_W-1:0] SEED_SECOND_OLDEST_RST = 32'd57964412;
  localparam logic [LAG_W-1:0] SEED_SECOND_MIDDLE_RST = 32'd12365487;
  localparam logic [LAG_W-1:0] SEED_SECOND_NEWEST_RST = 32'd77221456;

  typedef enum logic [IDX_W-1:0] {
    CFG_FIRST_OLDEST  = 3'd0,
    CFG_FIRST_MIDDLE  = 3'd1,
    CFG_FIRST_NEWEST  = 3'd2,
    CFG_SECOND_OLDEST = 3'd3,
    CFG_SECOND_MIDDLE = 3'd4,
    CFG_SECOND_NEWEST = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MUL_A,
    ALU_MUL_B,
    ALU_FOLD,
    ALU_RED,
    ALU_COMB,
    ALU_MIX
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_FOLD_A1,
    ST_FOLD_A2,
    ST_RED_A,
    ST_MUL_B,
    ST_FOLD_B1,
    ST_FOLD_B2,
    ST_RED_B,
    ST_COMB,
    ST_MIX
  } seq_state_e;

  typedef struct packed {
    alu_op_e op;
    logic    comp;
    logic    acc_en;
    logic    cap_t;
    logic    cap_p1;
    logic    shift_first;
    logic    shift_second;
    logic    load_out;
  } ctrl_t;

  typedef struct packed {
    logic [LAG_W-1:0] a_lag;
    logic [LAG_W-1:0] b_lag;
  } lag_view_t;

endpackage

`default_nettype wire

### design/mrg3_req_if.sv
// ----------------------------------------------------------------------------
// mrg3_req_if
// Request channel: valid/ready with the restart flag
// ----------------------------------------------------------------------------
`default_nettype none

interface mrg3_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

### design/mrg3_rsp_if.sv
// ----------------------------------------------------------------------------
// mrg3_rsp_if
// Result channel: valid/ready with the combined sample
// ----------------------------------------------------------------------------
`default_nettype none

interface mrg3_rsp_if
  import mrg3_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LAG_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

### design/combined_mrg_order3_rng_top.sv
// ----------------------------------------------------------------------------
// combined_mrg_order3_rng_top
// MRG32k3a integer generator: one 32-bit sample per request
// ----------------------------------------------------------------------------
// Each request produces one sample_value in 1..4294967087; a restart flag
// reloads all six lags from the seed registers first. The mixing step holds
// while the output register is full and not read, and the next request is
// taken the cycle after it. The steps come from the single shared 22x32
// multiply-add unit, used four times per term (product, two folds of 2^32,
// final subtract) for both terms of each component, plus one combine step
// per component and one mixing step. A finished sample waits in an output
// register while the next request is accepted and worked on.
`default_nettype none

`include "combined_mrg_order3_rng_top_defines.svh"

module combined_mrg_order3_rng_top
  import mrg3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  mrg3_req_if.sink         in_i,
  mrg3_rsp_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [LAG_W-1:0] cfg_data_i
);

  ctrl_t            ctrl;
  lag_view_t        lag_view;
  logic             in_ready;
  logic             slot_free;
  logic [ACC_W-1:0] alu_res;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [LAG_W-1:0] t_q, t_d;
  logic [LAG_W-1:0] p1_q, p1_d;
  logic [LAG_W-1:0] out_data_q, out_data_d;
  logic             out_vld_q, out_vld_d;

  assign slot_free = !out_vld_q || out_o.ready;
  assign in_i.ready = in_ready;

  mrg3_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .slot_free_i (slot_free),
    .in_ready_o  (in_ready),
    .ctrl_o      (ctrl)
  );

  mrg3_lags u_lags (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .load_i         (in_i.valid && in_ready && in_i.restart),
    .shift_first_i  (ctrl.shift_first),
    .shift_second_i (ctrl.shift_second),
    .new_first_i    (alu_res[LAG_W-1:0]),
    .new_second_i   (acc_q[LAG_W-1:0]),
    .comp_i         (ctrl.comp),
    .view_o         (lag_view)
  );

  mrg3_alu u_alu (
    .op_i   (ctrl.op),
    .comp_i (ctrl.comp),
    .acc_i  (acc_q),
    .lags_i (lag_view),
    .t_i    (t_q),
    .p1_i   (p1_q),
    .res_o  (alu_res)
  );

  always_comb begin
    acc_d      = ctrl.acc_en ? alu_res : acc_q;
    t_d        = ctrl.cap_t ? alu_res[LAG_W-1:0] : t_q;
    p1_d       = ctrl.cap_p1 ? alu_res[LAG_W-1:0] : p1_q;
    out_data_d = ctrl.load_out ? alu_res[LAG_W-1:0] : out_data_q;
    out_vld_d  = out_vld_q;
    if (ctrl.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    t_q        <= t_d;
    p1_q       <= p1_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.sample_value = out_data_q;

  `MRG3_ASSERT_IMP(a_out_from_mix, clk_i, rst_ni, $rose(out_vld_q), $past(ctrl.load_out))
  `MRG3_ASSERT_NXT(a_red_fits, clk_i, rst_ni, ctrl.op == ALU_RED, acc_q[ACC_W-1:LAG_W] == '0)

endmodule

`default_nettype wire

### design/mrg3_alu.sv
// ----------------------------------------------------------------------------
// mrg3_alu
// Shared multiply-add and modular subtract unit
// ----------------------------------------------------------------------------
`default_nettype none

module mrg3_alu
  import mrg3_pkg::*;
(
  input  alu_op_e          op_i,
  input  logic             comp_i,
  input  logic [ACC_W-1:0] acc_i,
  input  lag_view_t        lags_i,
  input  logic [LAG_W-1:0] t_i,
  input  logic [LAG_W-1:0] p1_i,
  output logic [ACC_W-1:0] res_o
);

  logic [COEF_W-1:0] mul_a;
  logic [LAG_W-1:0]  mul_b;
  logic [LAG_W-1:0]  add_c;
  logic [ACC_W-1:0]  mac;
  logic [LAG_W:0]    sx;
  logic [LAG_W:0]    sy;
  logic [LAG_W+1:0]  diff;
  logic              borrow;
  logic [LAG_W-1:0]  modulus;
  logic [LAG_W-1:0]  wrapped;

  assign modulus = comp_i ? MOD_TWO : MOD_ONE;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    add_c = '0;
    case (op_i)
      ALU_MUL_A: begin
        mul_a = comp_i ? MUL_TWO_A : MUL_ONE_A;
        mul_b = lags_i.a_lag;
      end
      ALU_MUL_B: begin
        mul_a = comp_i ? MUL_TWO_B : MUL_ONE_B;
        mul_b = lags_i.b_lag;
      end
      ALU_FOLD: begin
        mul_a = acc_i[ACC_W-1:LAG_W];
        mul_b = comp_i ? FOLD_TWO : FOLD_ONE;
        add_c = acc_i[LAG_W-1:0];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mac = ACC_W'(mul_a) * ACC_W'(mul_b) + ACC_W'(add_c);

  always_comb begin
    sx = '0;
    sy = '0;
    case (op_i)
      ALU_RED: begin
        sx = acc_i[LAG_W:0];
        sy = {1'b0, modulus};
      end
      ALU_COMB: begin
        sx = {1'b0, t_i};
        sy = {1'b0, acc_i[LAG_W-1:0]};
      end
      ALU_MIX: begin
        sx = {1'b0, p1_i};
        sy = {1'b0, acc_i[LAG_W-1:0]};
      end
      default: begin
        sx = '0;
      end
    endcase
  end

  assign diff    = {1'b0, sx} - {1'b0, sy};
  assign borrow  = diff[LAG_W+1];
  assign wrapped = diff[LAG_W-1:0] + ((op_i == ALU_MIX) ? MOD_ONE : modulus);

  always_comb begin
    res_o = '0;
    case (op_i)
      ALU_MUL_A, ALU_MUL_B, ALU_FOLD: begin
        res_o = mac;
      end
      ALU_RED: begin
        res_o = borrow ? ACC_W'(acc_i[LAG_W:0]) : ACC_W'(diff[LAG_W:0]);
      end
      ALU_COMB: begin
        res_o = borrow ? ACC_W'(wrapped) : ACC_W'(diff[LAG_W-1:0]);
      end
      ALU_MIX: begin
        // p1 <= p2 takes the wrap
        res_o = (borrow || (diff == '0)) ? ACC_W'(wrapped) : ACC_W'(diff[LAG_W-1:0]);
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mrg3_lags.sv
// ----------------------------------------------------------------------------
// mrg3_lags
// Seed registers and the three-deep lag lines of both components
// ----------------------------------------------------------------------------
`default_nettype none

module mrg3_lags
  import mrg3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [LAG_W-1:0] cfg_data_i,
  input  logic             load_i,
  input  logic             shift_first_i,
  input  logic             shift_second_i,
  input  logic [LAG_W-1:0] new_first_i,
  input  logic [LAG_W-1:0] new_second_i,
  input  logic             comp_i,
  output lag_view_t        view_o
);

  logic [LAG_W-1:0] seed_q [6];
  logic [LAG_W-1:0] seed_d [6];
  logic [LAG_W-1:0] first_q [3];
  logic [LAG_W-1:0] first_d [3];
  logic [LAG_W-1:0] second_q [3];
  logic [LAG_W-1:0] second_d [3];

  always_comb begin
    seed_d = seed_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_OLDEST:  seed_d[0] = cfg_data_i;
        CFG_FIRST_MIDDLE:  seed_d[1] = cfg_data_i;
        CFG_FIRST_NEWEST:  seed_d[2] = cfg_data_i;
        CFG_SECOND_OLDEST: seed_d[3] = cfg_data_i;
        CFG_SECOND_MIDDLE: seed_d[4] = cfg_data_i;
        CFG_SECOND_NEWEST: seed_d[5] = cfg_data_i;
        default: begin
          seed_d = seed_q;
        end
      endcase
    end
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (load_i) begin
      first_d  = '{seed_q[0], seed_q[1], seed_q[2]};
      second_d = '{seed_q[3], seed_q[4], seed_q[5]};
    end else begin
      if (shift_first_i) begin
        first_d = '{first_q[1], first_q[2], new_first_i};
      end
      if (shift_second_i) begin
        second_d = '{second_q[1], second_q[2], new_second_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '{SEED_FIRST_OLDEST_RST, SEED_FIRST_MIDDLE_RST, SEED_FIRST_NEWEST_RST,
                    SEED_SECOND_OLDEST_RST, SEED_SECOND_MIDDLE_RST,
                    SEED_SECOND_NEWEST_RST};
      first_q  <= '{SEED_FIRST_OLDEST_RST, SEED_FIRST_MIDDLE_RST, SEED_FIRST_NEWEST_RST};
      second_q <= '{SEED_SECOND_OLDEST_RST, SEED_SECOND_MIDDLE_RST,
                    SEED_SECOND_NEWEST_RST};
    end else begin
      seed_q   <= seed_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // component one uses middle and oldest, component two newest and oldest
  assign view_o.a_lag = comp_i ? second_q[2] : first_q[1];
  assign view_o.b_lag = comp_i ? second_q[0] : first_q[0];

endmodule

`default_nettype wire

### design/mrg3_seq.sv
// ----------------------------------------------------------------------------
// mrg3_seq
// Step sequencer driving the shared arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "combined_mrg_order3_rng_top_defines.svh"

module mrg3_seq
  import mrg3_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  slot_free_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  seq_state_e state_q, state_d;
  logic       comp_q, comp_d;

  always_comb begin
    state_d = state_q;
    comp_d  = comp_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_A;
          comp_d  = 1'b0;
        end
      end
      ST_MUL_A:   state_d = ST_FOLD_A1;
      ST_FOLD_A1: state_d = ST_FOLD_A2;
      ST_FOLD_A2: state_d = ST_RED_A;
      ST_RED_A:   state_d = ST_MUL_B;
      ST_MUL_B:   state_d = ST_FOLD_B1;
      ST_FOLD_B1: state_d = ST_FOLD_B2;
      ST_FOLD_B2: state_d = ST_RED_B;
      ST_RED_B:   state_d = ST_COMB;
      ST_COMB: begin
        if (!comp_q) begin
          state_d = ST_MUL_A;
          comp_d  = 1'b1;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.op   = ALU_NOP;
    ctrl_o.comp = comp_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MUL_A: begin
        ctrl_o.op     = ALU_MUL_A;
        ctrl_o.acc_en = 1'b1;
      end
      ST_FOLD_A1, ST_FOLD_A2, ST_FOLD_B1, ST_FOLD_B2: begin
        ctrl_o.op     = ALU_FOLD;
        ctrl_o.acc_en = 1'b1;
      end
      ST_RED_A: begin
        ctrl_o.op     = ALU_RED;
        ctrl_o.acc_en = 1'b1;
        ctrl_o.cap_t  = 1'b1;
      end
      ST_MUL_B: begin
        ctrl_o.op     = ALU_MUL_B;
        ctrl_o.acc_en = 1'b1;
      end
      ST_RED_B: begin
        ctrl_o.op     = ALU_RED;
        ctrl_o.acc_en = 1'b1;
      end
      ST_COMB: begin
        ctrl_o.op          = ALU_COMB;
        ctrl_o.acc_en      = 1'b1;
        ctrl_o.cap_p1      = !comp_q;
        ctrl_o.shift_first = !comp_q;
      end
      ST_MIX: begin
        ctrl_o.op           = ALU_MIX;
        ctrl_o.shift_second = slot_free_i;
        ctrl_o.load_out     = slot_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      comp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
    end
  end

  `MRG3_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `MRG3_ASSERT_NXT(a_comp_switch, clk_i, rst_ni, (state_q == ST_COMB) && !comp_q, (state_q == ST_MUL_A) && comp_q)
  `MRG3_ASSERT_IMP(a_mix_second, clk_i, rst_ni, state_q == ST_MIX, comp_q)

endmodule

`default_nettype wire

### tb/combined_mrg_order3_rng_top_tb.sv
// ----------------------------------------------------------------------------
// combined_mrg_order3_rng_top_tb
// Self-checking bench for the MRG32k3a sample generator. Requests with and
// without restart go in over the request channel. Every sample is checked
// against a recurrence kept inside the bench. The seed registers are
// reprogrammed between phases with zero, top-of-range and out-of-range seeds,
// and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module combined_mrg_order3_rng_top_tb;
  import mrg3_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_WAIT      = 13;
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam int unsigned PHASE_COUNT   = 15;
  localparam int unsigned SEED_COUNT    = 6;
  localparam int unsigned LAG_DEPTH     = 3;

  localparam logic [IDX_W-1:0] CFG_UNUSED_SIX   = 3'd6;
  localparam logic [IDX_W-1:0] CFG_UNUSED_SEVEN = 3'd7;

  typedef logic [LAG_W-1:0] seed_set_t [SEED_COUNT];

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [LAG_W-1:0] cfg_data_i;

  mrg3_req_if req_if ();
  mrg3_rsp_if rsp_if ();

  combined_mrg_order3_rng_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [LAG_W-1:0] seed_bank [SEED_COUNT];
  logic [LAG_W-1:0] lag_one [LAG_DEPTH];
  logic [LAG_W-1:0] lag_two [LAG_DEPTH];
  logic [LAG_W-1:0] pending_samples [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  bit               steady_flow = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // (mul_plus*lag_plus - mul_minus*lag_minus) mod modulus, exact
  function automatic logic [LAG_W-1:0] mrg_residue(
    input logic [COEF_W-1:0] mul_plus,
    input logic [LAG_W-1:0]  lag_plus,
    input logic [COEF_W-1:0] mul_minus,
    input logic [LAG_W-1:0]  lag_minus,
    input logic [LAG_W-1:0]  modulus
  );
    logic [63:0]      wide_mod;
    logic [63:0]      plus_part;
    logic [63:0]      minus_part;
    logic [63:0]      wide_res;
    logic [LAG_W-1:0] res;
    wide_mod   = 64'(modulus);
    plus_part  = (64'(mul_plus) * 64'(lag_plus)) % wide_mod;
    minus_part = (64'(mul_minus) * 64'(lag_minus)) % wide_mod;
    wide_res   = (plus_part + wide_mod - minus_part) % wide_mod;
    res        = wide_res[LAG_W-1:0];
    return res;
  endfunction

  function automatic logic [LAG_W-1:0] advance_generator(input logic restart);
    logic [LAG_W-1:0] p1;
    logic [LAG_W-1:0] p2;
    if (restart) begin
      for (int i = 0; i < LAG_DEPTH; i++) begin
        lag_one[i] = seed_bank[i];
        lag_two[i] = seed_bank[LAG_DEPTH + i];
      end
    end
    p1 = mrg_residue(MUL_ONE_A, lag_one[1], MUL_ONE_B, lag_one[0], MOD_ONE);
    lag_one = '{lag_one[1], lag_one[2], p1};
    p2 = mrg_residue(MUL_TWO_A, lag_two[2], MUL_TWO_B, lag_two[0], MOD_TWO);
    lag_two = '{lag_two[1], lag_two[2], p2};
    // true value stays below 2^32, so 32-bit wraparound gives it exactly
    if (p1 <= p2) begin
      return p1 + MOD_ONE - p2;
    end
    return p1 - p2;
  endfunction

  function automatic logic [LAG_W-1:0] draw_seed(input logic [LAG_W-1:0] modulus);
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return modulus - 1;
      end
      2: begin
        return '1;
      end
      3: begin
        return modulus + $urandom_range(0, ~modulus);
      end
      default: begin
        return $urandom_range(0, modulus - 1);
      end
    endcase
  endfunction

  task automatic send_request(input logic restart);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_samples.push_back(advance_generator(restart));
  endtask

  task automatic wait_for_samples();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
  endtask

  // unused indexes go last so a write that aliases onto a seed shows up
  task automatic program_seeds(input seed_set_t seeds);
    for (int i = 0; i < SEED_COUNT; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= seeds[i];
      @(posedge clk_i);
      seed_bank[i] = seeds[i];
    end
    cfg_idx_i  <= CFG_UNUSED_SIX;
    cfg_data_i <= $urandom();
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UNUSED_SEVEN;
    cfg_data_i <= $urandom();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_seeds();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_restart_back_to_back();
    steady_flow = 1'b1;
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    steady_flow = 1'b0;
  endtask

  task automatic test_seed_extremes();
    seed_set_t seeds;
    seed_set_t cases [6];
    cases[0] = '{default: '0};
    cases[1] = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3};
    cases[2] = '{MOD_ONE - 1, MOD_ONE - 1, MOD_ONE - 1, 32'd0, 32'd0, 32'd0};
    cases[3] = '{MOD_ONE - 1, MOD_ONE - 1, MOD_ONE - 1,
                 MOD_TWO - 1, MOD_TWO - 1, MOD_TWO - 1};
    cases[4] = '{default: '1};
    cases[5] = '{MOD_ONE, MOD_ONE + 1, 32'hFFFF_FFFF, MOD_TWO, MOD_TWO + 1, 32'hFFFF_FFFF};
    for (int c = 0; c < 6; c++) begin
      seeds = cases[c];
      wait_for_samples();
      program_seeds(seeds);
      send_request(1'b1);
      send_request(1'b0);
    end
    send_request(1'b0);
  endtask

  task automatic test_drain_between_bursts();
    steady_flow = 1'b1;
    repeat (6) send_request(1'b0);
    wait_for_samples();
    repeat (6) send_request(1'b0);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_stream();
    seed_set_t seeds;
    logic      restart;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_for_samples();
      for (int i = 0; i < SEED_COUNT; i++) begin
        seeds[i] = draw_seed(i < LAG_DEPTH ? MOD_ONE : MOD_TWO);
      end
      program_seeds(seeds);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) begin
          steady_flow = ($urandom_range(0, 3) == 0);
        end
        if (n == 0) begin
          restart = ($urandom_range(0, 3) != 0);
        end else begin
          restart = ($urandom_range(0, 15) == 0);
        end
        send_request(restart);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    int unsigned      stall;
    logic [LAG_W-1:0] wanted;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: sample_value expected none, got %0d", $time, rsp_if.sample_value);
      end else begin
        wanted = pending_samples.pop_front();
        if (rsp_if.sample_value !== wanted) begin
          mismatch_count++;
          $display("%0t: sample_value expected %0d, got %0d",
                   $time, wanted, rsp_if.sample_value);
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_FIRST_OLDEST;
    cfg_data_i     <= '0;
    seed_bank = '{SEED_FIRST_OLDEST_RST, SEED_FIRST_MIDDLE_RST, SEED_FIRST_NEWEST_RST,
                  SEED_SECOND_OLDEST_RST, SEED_SECOND_MIDDLE_RST, SEED_SECOND_NEWEST_RST};
    for (int i = 0; i < LAG_DEPTH; i++) begin
      lag_one[i] = seed_bank[i];
      lag_two[i] = seed_bank[LAG_DEPTH + i];
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_seeds();
    test_restart_back_to_back();
    test_seed_extremes();
    test_drain_between_bursts();
    test_random_stream();

    wait_for_samples();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### combined_mrg_order3_rng_top.f
+incdir+design
design/mrg3_pkg.sv
design/mrg3_req_if.sv
design/mrg3_rsp_if.sv
design/mrg3_alu.sv
design/mrg3_lags.sv
design/mrg3_seq.sv
design/combined_mrg_order3_rng_top.sv
tb/combined_mrg_order3_rng_top_tb.sv
